>>> sv/cmpt_pkg.sv
// ----------------------------------------------------------------------------
// cmpt_pkg
// Shared types and constants for the CAN message period table.
// ----------------------------------------------------------------------------
package cmpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] REG_DEAD_TIME      = 2'd0;
    localparam logic [1:0] REG_MAX_PERIOD     = 2'd1;
    localparam logic [1:0] REG_SWEEP_INTERVAL = 2'd2;

    localparam logic [31:0] DEAD_TIME_RST      = 32'd10000;
    localparam logic [31:0] MAX_PERIOD_RST     = 32'd2000;
    localparam logic [31:0] SWEEP_INTERVAL_RST = 32'd250;

    localparam logic [1:0] ST_NEW       = 2'd0;
    localparam logic [1:0] ST_REPEAT    = 2'd1;
    localparam logic [1:0] ST_CHANGED   = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [31:0] last_seen;
        logic [31:0] period;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SWEEP,
        S_OUT
    } state_t;

    // Memory access request from the controller.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (len > 4'(b)) m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

>>> sv/can_message_period_table.sv
// ----------------------------------------------------------------------------
// can_message_period_table
// Table of CAN identifiers with change detection, period measurement and aging.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    frame_id, frame_len, payload, now_ms
//  m_        out        m_valid / m_ready    status .. entries_used
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From input transfer to result, a frame goes through the lookup scan, the entry
// update and, when one is due, the aging sweep; each pass reads the entry memory once a cycle.
// After the result transfer the block returns to idle before it takes the next frame.
// Reset clears live and period-valid flags at once; entry contents need none.
// A frame is accepted only when the previous result has been transferred.
module can_message_period_table import cmpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_frame_id,
    input  logic [3:0]  s_frame_len,
    input  logic [63:0] s_payload,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_period_valid,
    output logic [31:0] m_period_ms,
    output logic        m_sweep_done,
    output logic [6:0]  m_removed_count,
    output logic [6:0]  m_entries_used,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] dead_reg, maxp_reg, swi_reg;
    logic        busy;
    mem_req_t    req;
    entry_t      rd_data;
    logic [CNT_W-1:0] rem, used;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_reg <= DEAD_TIME_RST;
            maxp_reg <= MAX_PERIOD_RST;
            swi_reg  <= SWEEP_INTERVAL_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_DEAD_TIME)      dead_reg <= cfg_data;
            if (cfg_index == REG_MAX_PERIOD)     maxp_reg <= cfg_data;
            if (cfg_index == REG_SWEEP_INTERVAL) swi_reg  <= cfg_data;
        end
    end

    cmpt_entry_ram u_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    cmpt_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (s_valid && s_ready),
        .frame_id          (s_frame_id),
        .frame_len         (s_frame_len),
        .payload           (s_payload),
        .now_ms            (s_now_ms),
        .dead_time_ms      (dead_reg),
        .max_period_ms     (maxp_reg),
        .sweep_interval_ms (swi_reg),
        .rd_data           (rd_data),
        .req               (req),
        .busy              (busy),
        .res_valid         (m_valid),
        .res_taken         (m_ready),
        .status            (m_status),
        .period_valid      (m_period_valid),
        .period_ms         (m_period_ms),
        .sweep_done        (m_sweep_done),
        .removed_count     (rem),
        .entries_used      (used)
    );

    assign m_removed_count = 7'(rem);
    assign m_entries_used  = 7'(used);

endmodule

>>> sv/cmpt_entry_ram.sv
// ----------------------------------------------------------------------------
// cmpt_entry_ram
// Simple dual-port entry memory (one write port, one read port) with registered read data.
// ----------------------------------------------------------------------------
module cmpt_entry_ram import cmpt_pkg::*; (
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

>>> sv/cmpt_ctrl.sv
// ----------------------------------------------------------------------------
// cmpt_ctrl
// Sequencer: lookup scan, entry update and aging sweep over the entry memory.
// ----------------------------------------------------------------------------
module cmpt_ctrl import cmpt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       frame_id,
    input  logic [3:0]        frame_len,
    input  logic [63:0]       payload,
    input  logic [31:0]       now_ms,
    input  logic [31:0]       dead_time_ms,
    input  logic [31:0]       max_period_ms,
    input  logic [31:0]       sweep_interval_ms,
    input  entry_t            rd_data,
    output mem_req_t          req,
    output logic              busy,
    output logic              res_valid,
    input  logic              res_taken,
    output logic [1:0]        status,
    output logic              period_valid,
    output logic [31:0]       period_ms,
    output logic              sweep_done,
    output logic [CNT_W-1:0]  removed_count,
    output logic [CNT_W-1:0]  entries_used
);

    state_t state_reg, state_next;
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    logic [TABLE_DEPTH-1:0] pok_reg, pok_next;
    logic [31:0] last_sweep_reg, last_sweep_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;     // address of the read in flight + 1
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    entry_t           hit_ent_reg, hit_ent_next;
    logic [31:0] id_reg, now_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;
    logic [1:0]  status_reg, status_next;
    logic        pv_reg, pv_next;
    logic [31:0] pms_reg, pms_next;
    logic        sw_reg, sw_next;
    logic [CNT_W-1:0] rem_reg, rem_next;

    logic [31:0] per, age;
    logic        changed;
    logic [63:0] m;

    assign m       = byte_mask(len_reg);
    assign per     = now_reg - hit_ent_reg.last_seen;
    assign changed = (hit_ent_reg.len != len_reg) || ((hit_ent_reg.data & m) != (data_reg & m));
    assign age     = now_reg - rd_data.last_seen;

    always_ff @(posedge aclk) begin
        if (start) begin
            id_reg   <= frame_id;
            len_reg  <= frame_len;
            data_reg <= payload;
            now_reg  <= now_ms;
        end
        hit_ent_reg  <= hit_ent_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        rd_idx_reg   <= rd_idx_next;
        pms_reg      <= pms_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            live_reg       <= '0;
            pok_reg        <= '0;
            last_sweep_reg <= '0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            status_reg     <= ST_NEW;
            pv_reg         <= 1'b0;
            sw_reg         <= 1'b0;
            rem_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            pok_reg        <= pok_next;
            last_sweep_reg <= last_sweep_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            status_reg     <= status_next;
            pv_reg         <= pv_next;
            sw_reg         <= sw_next;
            rem_reg        <= rem_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        live_next       = live_reg;
        pok_next        = pok_reg;
        last_sweep_next = last_sweep_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        hit_ent_next    = hit_ent_reg;
        status_next     = status_reg;
        pv_next         = pv_reg;
        pms_next        = pms_reg;
        sw_next         = sw_reg;
        rem_next        = rem_reg;
        req             = '0;
        req.rd_addr     = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                end
            end
            S_SCAN: begin
                // Issue one read per cycle; examine the entry read last cycle.
                if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    req.rd_addr  = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    if (live_reg[rd_idx_reg]) begin
                        if (!hit_reg && rd_data.id == id_reg) begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                            hit_ent_next = rd_data;
                        end
                    end else if (!free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end else if (cnt_reg == CNT_W'(TABLE_DEPTH)) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                pv_next  = 1'b0;
                pms_next = '0;
                if (hit_reg) begin
                    status_next       = changed ? ST_CHANGED : ST_REPEAT;
                    req.wr_en         = 1'b1;
                    req.wr_addr       = hit_idx_reg;
                    req.wr_data.id    = id_reg;
                    req.wr_data.len   = len_reg;
                    req.wr_data.data  = data_reg;
                    req.wr_data.last_seen = now_reg;
                    req.wr_data.period    = per;
                    pok_next[hit_idx_reg] = (per <= max_period_ms);
                    if (per <= max_period_ms) begin
                        pv_next  = 1'b1;
                        pms_next = per;
                    end
                end else if (free_reg) begin
                    status_next       = ST_NEW;
                    req.wr_en         = 1'b1;
                    req.wr_addr       = free_idx_reg;
                    req.wr_data.id    = id_reg;
                    req.wr_data.len   = len_reg;
                    req.wr_data.data  = data_reg;
                    req.wr_data.last_seen = now_reg;
                    req.wr_data.period    = '0;
                    live_next[free_idx_reg] = 1'b1;
                    pok_next[free_idx_reg]  = 1'b0;
                end else begin
                    status_next = ST_DROPPED;
                end
                rem_next = '0;
                cnt_next = '0;
                if ((now_reg - last_sweep_reg) >= sweep_interval_ms) begin
                    sw_next         = 1'b1;
                    last_sweep_next = now_reg;
                    state_next      = S_SWEEP;
                end else begin
                    sw_next    = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_SWEEP: begin
                // The update write lands before the first sweep read, so no forwarding.
                if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    req.rd_addr  = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    if (live_reg[rd_idx_reg]) begin
                        if (age > dead_time_ms) begin
                            live_next[rd_idx_reg] = 1'b0;
                            pok_next[rd_idx_reg]  = 1'b0;
                            rem_next = rem_reg + 1'b1;
                        end else if (pok_reg[rd_idx_reg] &&
                                     {1'b0, age} > {rd_data.period, 1'b0}) begin
                            pok_next[rd_idx_reg] = 1'b0;
                        end
                    end
                end else if (cnt_reg == CNT_W'(TABLE_DEPTH)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (res_taken) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign res_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign period_valid  = pv_reg;
    assign period_ms     = pms_reg;
    assign sweep_done    = sw_reg;
    assign removed_count = rem_reg;
    assign entries_used  = CNT_W'($countones(live_reg));

    a_pv_ms: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !period_valid |-> period_ms == '0)
        else $error("period_ms nonzero without a valid period");
    a_nosweep: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !sweep_done |-> removed_count == '0)
        else $error("entries removed without a sweep");
    a_pok_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (pok_reg & ~live_reg) == '0)
        else $error("valid period on a free entry");

endmodule

>>> dv/can_message_period_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_message_period_table_test
// Self-checking bench for the CAN message period table. Frames are streamed
// with random gaps and back-pressure. A tracker keeps its own copy of the
// identifier table and registers, works out each frame's outcome and compares
// it field by field with the transfers seen on the result channel.
// ----------------------------------------------------------------------------
module can_message_period_table_test;
    import cmpt_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic        period_valid;
        logic [31:0] period_ms;
        logic        sweep_done;
        logic [6:0]  removed_count;
        logic [6:0]  entries_used;
    } outcome_t;

    class frame_outcome_tracker;
        logic [31:0] dead_time, max_period, sweep_interval, last_sweep;
        bit          live[TABLE_DEPTH];
        bit          period_ok[TABLE_DEPTH];
        logic [31:0] ids[TABLE_DEPTH];
        logic [3:0]  lens[TABLE_DEPTH];
        logic [63:0] datas[TABLE_DEPTH];
        logic [31:0] seen_at[TABLE_DEPTH];
        logic [31:0] periods[TABLE_DEPTH];
        outcome_t    expected_outcomes[$];
        int          errors;

        function new();
            dead_time      = DEAD_TIME_RST;
            max_period     = MAX_PERIOD_RST;
            sweep_interval = SWEEP_INTERVAL_RST;
            last_sweep     = '0;
            errors         = 0;
            foreach (live[i]) begin
                live[i]      = 0;
                period_ok[i] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_DEAD_TIME:      dead_time = v;
                REG_MAX_PERIOD:     max_period = v;
                REG_SWEEP_INTERVAL: sweep_interval = v;
                default: ;
            endcase
        endfunction

        function void note_frame(logic [31:0] id, logic [3:0] len, logic [63:0] data,
                                 logic [31:0] now);
            outcome_t    o;
            int          hit, free_slot;
            logic [63:0] m;
            logic [31:0] per, age;
            hit = -1;
            free_slot = -1;
            o = '{ST_DROPPED, 1'b0, 32'd0, 1'b0, 7'd0, 7'd0};
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i]) begin
                    if (hit < 0 && ids[i] == id) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                m = '0;
                for (int b = 0; b < 8; b++)
                    if (len > b) m[b*8 +: 8] = 8'hFF;
                per = now - seen_at[hit];
                o.status = (lens[hit] != len || (datas[hit] & m) != (data & m)) ?
                           ST_CHANGED : ST_REPEAT;
                lens[hit] = len;
                datas[hit] = data;
                periods[hit] = per;
                period_ok[hit] = (per <= max_period);
                seen_at[hit] = now;
                if (period_ok[hit]) begin
                    o.period_valid = 1;
                    o.period_ms = per;
                end
            end else if (free_slot >= 0) begin
                o.status = ST_NEW;
                live[free_slot] = 1;
                ids[free_slot] = id;
                lens[free_slot] = len;
                datas[free_slot] = data;
                seen_at[free_slot] = now;
                periods[free_slot] = '0;
                period_ok[free_slot] = 0;
            end
            if (now - last_sweep >= sweep_interval) begin
                o.sweep_done = 1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (live[i]) begin
                        age = now - seen_at[i];
                        if (age > dead_time) begin
                            live[i] = 0;
                            period_ok[i] = 0;
                            o.removed_count++;
                        end else if (period_ok[i] && {1'b0, age} > {periods[i], 1'b0}) begin
                            period_ok[i] = 0;
                        end
                    end
                end
                last_sweep = now;
            end
            foreach (live[i]) if (live[i]) o.entries_used++;
            expected_outcomes.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t e;
            if (expected_outcomes.size() == 0) begin
                $error("result transfer with no frame outstanding");
                errors++;
                return;
            end
            e = expected_outcomes.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status); errors++;
            end
            if (got.period_valid !== e.period_valid) begin
                $error("period_valid: expected %0d, got %0d", e.period_valid,
                       got.period_valid); errors++;
            end
            if (got.period_ms !== e.period_ms) begin
                $error("period_ms: expected %0d, got %0d", e.period_ms, got.period_ms);
                errors++;
            end
            if (got.sweep_done !== e.sweep_done) begin
                $error("sweep_done: expected %0d, got %0d", e.sweep_done, got.sweep_done);
                errors++;
            end
            if (got.removed_count !== e.removed_count) begin
                $error("removed_count: expected %0d, got %0d", e.removed_count,
                       got.removed_count); errors++;
            end
            if (got.entries_used !== e.entries_used) begin
                $error("entries_used: expected %0d, got %0d", e.entries_used,
                       got.entries_used); errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_valid, s_ready;
    logic [31:0] s_frame_id, s_now_ms;
    logic [3:0]  s_frame_len;
    logic [63:0] s_payload;
    logic        m_valid, m_ready;
    logic [1:0]  m_status;
    logic        m_period_valid, m_sweep_done;
    logic [31:0] m_period_ms;
    logic [6:0]  m_removed_count, m_entries_used;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_outcome_tracker tracker = new();

    bit          no_idle;
    bit          hold_toggle, hold_seen;
    int          hold_left;
    logic [31:0] clock_ms;

    // Identifier pool so that most frames repeat a known identifier.
    logic [31:0] pool_id[12];
    logic [3:0]  pool_len[12];
    logic [63:0] pool_data[12];

    can_message_period_table DUT (.*);

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random back-pressure plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_toggle;
        end else begin
            if (m_valid && m_ready)
                tracker.check_result('{m_status, m_period_valid, m_period_ms,
                                       m_sweep_done, m_removed_count, m_entries_used});
            if (hold_seen != hold_toggle) begin
                hold_seen <= hold_toggle;
                hold_left <= 2000;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 28);
            end
        end
    end

    task automatic send_frame(logic [31:0] id, logic [3:0] len, logic [63:0] data,
                              logic [31:0] now);
        s_valid     <= 1'b1;
        s_frame_id  <= id;
        s_frame_len <= len;
        s_payload   <= data;
        s_now_ms    <= now;
        do @(posedge aclk); while (!s_ready);
        tracker.note_frame(id, len, data, now);
        if (!no_idle && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 28);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [31:0] dead, logic [31:0] maxp, logic [31:0] sweep);
        drain();
        write_reg(REG_DEAD_TIME, dead);
        write_reg(REG_MAX_PERIOD, maxp);
        write_reg(REG_SWEEP_INTERVAL, sweep);
    endtask

    task automatic advance_clock();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)      clock_ms = clock_ms;
        else if (pick < 55) clock_ms = clock_ms + $urandom_range(1, 60);
        else if (pick < 85) clock_ms = clock_ms + $urandom_range(61, 3000);
        else if (pick < 97) clock_ms = clock_ms + $urandom_range(3001, 20000);
        else                clock_ms = $urandom;
    endtask

    task automatic random_frames(int n);
        int          k;
        logic [63:0] d;
        for (int i = 0; i < n; i++) begin
            advance_clock();
            k = $urandom_range(11);
            if ($urandom_range(99) < 8) begin
                send_frame($urandom, $urandom_range(15), {$urandom, $urandom}, clock_ms);
            end else begin
                case ($urandom_range(3))
                    0: begin
                        pool_len[k]  = $urandom_range(15);
                        pool_data[k] = {$urandom, $urandom};
                    end
                    1: begin
                        // Disturb only bytes past the length: still a repeat.
                        d = {$urandom, $urandom};
                        for (int b = 0; b < 8; b++)
                            if (pool_len[k] > b) d[b*8 +: 8] = pool_data[k][b*8 +: 8];
                        pool_data[k] = d;
                    end
                    default: ;
                endcase
                send_frame(pool_id[k], pool_len[k], pool_data[k], clock_ms);
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_frame_id  = '0;
        s_frame_len = '0;
        s_payload   = '0;
        s_now_ms    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        hold_toggle = 1'b0;
        clock_ms    = '0;
        foreach (pool_id[i]) begin
            pool_id[i]   = (i < 4) ? i : $urandom;
            pool_len[i]  = $urandom_range(8);
            pool_data[i] = {$urandom, $urandom};
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at reset register values.
        send_frame(32'h0, 4'd0, 64'h0, 32'd0);
        send_frame(32'hFFFF_FFFF, 4'd8, '1, 32'd1);
        send_frame(32'h0, 4'd0, '1, 32'd10);
        send_frame(32'h0, 4'd15, 64'h1122_3344_5566_7788, 32'd20);
        send_frame(32'h0, 4'd15, 64'h1122_3344_5566_7788, 32'd30);
        send_frame(32'h0, 4'd3, 64'h0000_0000_0066_7788, 32'd40);
        send_frame(32'h0, 4'd3, 64'hAA00_0000_0066_7788, 32'd50);
        send_frame(32'h0, 4'd3, 64'hAA00_0000_0066_7789, 32'd60);
        send_frame(32'hFFFF_FFFF, 4'd8, '1, 32'd300);
        send_frame(32'h0, 4'd3, 64'h7789, 32'd3100);
        send_frame(32'h0, 4'd3, 64'h7789, 32'd3110);
        send_frame(32'h1, 4'd1, 64'h5, 32'd3400);
        send_frame(32'h0, 4'd3, 64'h7789, 32'd3500);
        send_frame(32'h0, 4'd3, 64'h7789, 32'hFFFF_FFF0);
        send_frame(32'h0, 4'd3, 64'h7789, 32'h0000_0010);
        send_frame(32'h8000_0000, 4'd2, 64'h1, 32'h0000_0020);
        send_frame(32'h0, 4'd3, 64'h7789, 32'h0000_9000);
        clock_ms = 32'h9000;
        random_frames(120);

        // No back-pressure at all for a while.
        no_idle = 1'b1;
        random_frames(60);
        no_idle = 1'b0;

        // Widest registers: fill the table past its depth so frames drop.
        set_regs('1, '1, '1);
        write_reg(2'd3, '1);
        for (int i = 0; i < TABLE_DEPTH + 6; i++)
            send_frame(32'h1000_0000 + i, 4'd8, {$urandom, $urandom}, clock_ms + i);
        clock_ms = clock_ms + 100;
        random_frames(40);

        // Zero registers: every frame sweeps, and every entry older than the frame's time ages out.
        set_regs('0, '0, '0);
        random_frames(80);

        // Middle values with the receiver held off while the next frame waits at the input.
        set_regs(32'd5000, 32'd1000, 32'd100);
        hold_toggle <= ~hold_toggle;
        random_frames(20);
        drain();
        random_frames(100);

        set_regs(DEAD_TIME_RST, MAX_PERIOD_RST, SWEEP_INTERVAL_RST);
        random_frames(80);

        drain();
        if (tracker.errors == 0 && tracker.expected_outcomes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
